/* rtl/core/lse_pkg.sv */
// lse_pkg: shared constants and types of the lzw stream encoder
// no dependencies; imported by lzw_stream_encoder and lse_checker
package lse_pkg;
    localparam int DICT_SIZE = 4096;
    localparam int CODE_W    = $clog2(DICT_SIZE);
    localparam int LINK_W    = CODE_W + 1;
    localparam int NFC_W     = CODE_W + 1;
    localparam int SYM_W     = 8;
    localparam int NODE_W    = LINK_W + SYM_W;
    localparam int OUT_W     = 12;
    localparam int NUM_BYTES = 256;

    localparam logic [1:0] OP_PRESCAN = 2'd0;
    localparam logic [1:0] OP_ENCODE  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_RSVD    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REG,
        ST_CHILD,
        ST_WALK,
        ST_INS1,
        ST_INS2,
        ST_OUT1,
        ST_EOM,
        ST_OUT2
    } t_state;
endpackage

/* rtl/core/lse_ram.sv */
// lse_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module lse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/lzw_stream_encoder.sv */
// lzw_stream_encoder: two-pass lzw encoder with a linked (prefix, byte) dictionary
// depends on lse_pkg and lse_ram
//
// input channel: i_valid / o_stall with i_opcode, i_data_byte, i_end_of_message.
// opcode prescan registers a byte value, encode extends the current phrase,
// clear empties the tables in the cycle it is accepted.
// output channel: o_valid / i_stall with o_out_code, o_final_code; one output
// register holds a word while the receiver stalls, and the sequencer waits
// for it to drain before loading the next word.
// an encode word goes through ST_REG and, with a phrase open, ST_CHILD and an
// ST_WALK step per sibling visited on the child list of the phrase code, then
// ST_INS1 and ST_INS2 for an insert (ST_INS1 alone once the dictionary is full)
// and ST_OUT1 per emitted word, waiting on any receiver stall; a prescan word
// goes through ST_REG alone; the single read port of each ram sets these steps.
// o_stall is high while a word is in progress.
// reset (synchronous, active low) empties the dictionary and drops any open
// phrase; table rams need no clearing pass, entries above the fill count are
// never read.
module lzw_stream_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_message,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lse_pkg::OUT_W-1:0]   o_out_code,
    output logic                        o_final_code
);
    import lse_pkg::*;

    t_state                r_state, n_state;
    logic [1:0]            r_op, n_op;
    logic [SYM_W-1:0]      r_byte, n_byte;
    logic                  r_eom, n_eom;
    logic [NUM_BYTES-1:0]  r_seen, n_seen;
    logic [NFC_W-1:0]      r_nfc, n_nfc;
    logic [CODE_W-1:0]     r_phrase, n_phrase;
    logic                  r_active, n_active;
    logic [CODE_W-1:0]     r_bc, n_bc;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_link, n_link;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_W-1:0]      r_out_code, n_out_code;
    logic                  r_out_final, n_out_final;

    logic                  bc_we;
    logic [SYM_W-1:0]      bc_raddr;
    logic [CODE_W-1:0]     bc_rdata;
    logic                  ch_we;
    logic [CODE_W-1:0]     ch_waddr, ch_raddr;
    logic [LINK_W-1:0]     ch_wdata, ch_rdata;
    logic                  nd_we;
    logic [CODE_W-1:0]     nd_waddr, nd_raddr;
    logic [NODE_W-1:0]     nd_wdata, nd_rdata;

    logic                  full;
    logic                  out_free;
    logic [CODE_W-1:0]     bc;
    logic [LINK_W-1:0]     sib;

    lse_ram #(.WIDTH(CODE_W), .DEPTH(NUM_BYTES)) u_byte_code (
        .i_clk   (i_clk),
        .i_we    (bc_we),
        .i_waddr (r_byte),
        .i_wdata (r_nfc[CODE_W-1:0]),
        .i_raddr (bc_raddr),
        .o_rdata (bc_rdata)
    );

    lse_ram #(.WIDTH(LINK_W), .DEPTH(DICT_SIZE)) u_child (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wdata),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rdata)
    );

    lse_ram #(.WIDTH(NODE_W), .DEPTH(DICT_SIZE)) u_node (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    assign full     = (r_nfc == NFC_W'(DICT_SIZE));
    assign out_free = !r_out_valid || !i_stall;
    assign sib      = nd_rdata[NODE_W-1:SYM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_nfc       <= '0;
            r_phrase    <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_nfc       <= n_nfc;
            r_phrase    <= n_phrase;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_byte      <= n_byte;
        r_eom       <= n_eom;
        r_bc        <= n_bc;
        r_head      <= n_head;
        r_link      <= n_link;
        r_out_code  <= n_out_code;
        r_out_final <= n_out_final;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_byte      = r_byte;
        n_eom       = r_eom;
        n_seen      = r_seen;
        n_nfc       = r_nfc;
        n_phrase    = r_phrase;
        n_active    = r_active;
        n_bc        = r_bc;
        n_head      = r_head;
        n_link      = r_link;
        n_out_valid = r_out_valid && i_stall;
        n_out_code  = r_out_code;
        n_out_final = r_out_final;
        bc_we       = 1'b0;
        bc_raddr    = r_byte;
        ch_we       = 1'b0;
        ch_waddr    = r_nfc[CODE_W-1:0];
        ch_wdata    = '0;
        ch_raddr    = r_phrase;
        nd_we       = 1'b0;
        nd_waddr    = r_nfc[CODE_W-1:0];
        nd_wdata    = {{LINK_W{1'b0}}, r_byte};
        nd_raddr    = '0;
        bc          = '0;
        o_stall     = 1'b1;

        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                bc_raddr = i_data_byte;
                if (i_valid) begin
                    n_op   = i_opcode;
                    n_byte = i_data_byte;
                    n_eom  = i_end_of_message;
                    case (i_opcode)
                        OP_PRESCAN, OP_ENCODE: begin
                            n_state = ST_REG;
                        end
                        OP_CLEAR: begin
                            n_seen   = '0;
                            n_nfc    = '0;
                            n_phrase = '0;
                            n_active = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REG: begin
                if (r_seen[r_byte]) begin
                    bc = bc_rdata;
                end else if (!full) begin
                    bc             = r_nfc[CODE_W-1:0];
                    bc_we          = 1'b1;
                    ch_we          = 1'b1;
                    nd_we          = 1'b1;
                    n_seen[r_byte] = 1'b1;
                    n_nfc          = r_nfc + NFC_W'(1);
                end
                n_bc = bc;
                if (r_op == OP_PRESCAN) begin
                    n_state = ST_IDLE;
                end else if (!r_active) begin
                    n_phrase = bc;
                    n_active = 1'b1;
                    n_state  = ST_EOM;
                end else begin
                    n_state = ST_CHILD;
                end
            end
            ST_CHILD: begin
                n_head   = ch_rdata;
                n_link   = ch_rdata;
                nd_raddr = CODE_W'(ch_rdata - LINK_W'(1));
                n_state  = (ch_rdata == '0) ? ST_INS1 : ST_WALK;
            end
            ST_WALK: begin
                nd_raddr = CODE_W'(sib - LINK_W'(1));
                if (nd_rdata[SYM_W-1:0] == r_byte) begin
                    n_phrase = CODE_W'(r_link - LINK_W'(1));
                    n_state  = ST_EOM;
                end else if (sib == '0) begin
                    n_state = ST_INS1;
                end else begin
                    n_link = sib;
                end
            end
            ST_INS1: begin
                if (!full) begin
                    ch_we    = 1'b1;
                    nd_we    = 1'b1;
                    nd_wdata = {r_head, r_byte};
                    n_state  = ST_INS2;
                end else begin
                    n_state = ST_OUT1;
                end
            end
            ST_INS2: begin
                ch_we    = 1'b1;
                ch_waddr = r_phrase;
                ch_wdata = LINK_W'(r_nfc) + LINK_W'(1);
                n_nfc    = r_nfc + NFC_W'(1);
                n_state  = ST_OUT1;
            end
            ST_OUT1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = OUT_W'(r_phrase);
                    n_out_final = 1'b0;
                    n_phrase    = r_bc;
                    n_state     = ST_EOM;
                end
            end
            ST_EOM: begin
                n_state = r_eom ? ST_OUT2 : ST_IDLE;
            end
            ST_OUT2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = OUT_W'(r_phrase);
                    n_out_final = 1'b1;
                    n_phrase    = '0;
                    n_active    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_out_code   = r_out_code;
    assign o_final_code = r_out_final;
endmodule

/* rtl/core/lse_checker.sv */
// lse_checker: port-level assertions for lzw_stream_encoder, bound to the top level
// depends on lse_pkg
module lse_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [1:0]                i_opcode,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [lse_pkg::OUT_W-1:0] o_out_code,
    input logic                      o_final_code
);
    import lse_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_code) && $stable(o_final_code))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // clear completes in the cycle it is taken
    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode == OP_CLEAR |=> !o_stall)
        else $error("clear left the encoder busy");

    // an encode word keeps the encoder busy in the next cycle
    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode == OP_ENCODE |=> o_stall)
        else $error("encoder ready right after an encode word");
endmodule

bind lzw_stream_encoder lse_checker u_lse_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_opcode         (i_opcode),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_out_code       (o_out_code),
    .o_final_code     (o_final_code)
);
